### rtl/swrs_pkg.sv
// Shared constants and types for the sliding-window rank-select filter.
`timescale 1ns / 1ps
`default_nettype none

package swrs_pkg;

  localparam int WindowMax = 64;
  localparam int DataW     = 32;
  localparam int CntW      = $clog2(WindowMax + 1);
  localparam int IdxW      = $clog2(WindowMax);

  typedef logic signed [DataW-1:0] smp_t;
  typedef logic [CntW-1:0]         cnt_t;
  typedef logic [IdxW-1:0]         idx_t;

  // Control broadcast from the top level to every cell of the sorted chain.
  typedef struct packed {
    logic upd;     // apply removal and insertion this cycle
    logic rem;     // remove one copy of vold before inserting
    smp_t vold;    // value that leaves the window
    smp_t sample;  // value that enters the window
  } chain_ctl_t;

endpackage

`default_nettype wire

### rtl/sliding_window_rank_select.sv
// Top level of the sliding-window rank-select filter.
`timescale 1ns / 1ps
`default_nettype none

// Sliding-window rank-order filter. The block keeps the last window_size
// samples (1 to 64, written through cfg_we_i / cfg_wdata_i; 0 counts as 1 and
// values above 64 count as 64) both in arrival order, in a 64-entry ring
// memory, and in ascending order, in a row of 64 cells where each cell holds
// one entry and trades data with its two neighbors. Every item brings a sample
// and a rank. Once the window is full, a new sample evicts the oldest one.
// Every item after which the window holds window_size samples returns the
// rank-th smallest sample of the window, or value 0 with rank_error set when
// the rank is 0 or above the window size. Items that leave the window short of
// full return no result. At the accepting edge the ring memory reads the oldest
// sample, at the next edge all cells remove that sample and insert the new one
// in a single shift, and the result is loaded into the output register at the
// edge that may already accept the next item. The output register decouples the
// two channels, so an unclaimed result only stalls input once a second result is
// ready. Writing window_size empties the window; write it only while the
// block is idle. No initialization pass is needed after reset.
module sliding_window_rank_select (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       cfg_we_i,
  input  wire [swrs_pkg::CntW-1:0]  cfg_wdata_i,
  input  wire                       in_valid_i,
  output logic                      in_ready_o,
  input  wire  signed [swrs_pkg::DataW-1:0] sample_i,
  input  wire  [swrs_pkg::CntW-1:0] rank_i,
  output logic                      out_valid_o,
  input  wire                       out_ready_i,
  output logic signed [swrs_pkg::DataW-1:0] value_o,
  output logic                      rank_error_o
);
  import swrs_pkg::*;

  // Configuration and window bookkeeping.
  cnt_t win_q, win_d;
  cnt_t fill_q, fill_d;
  idx_t oldest_q, oldest_d;

  // Sequencing flags.
  logic upd_q, upd_d;
  logic sel_q, sel_d;
  logic out_valid_q, out_valid_d;

  // Item payload and result registers.
  smp_t sample_q;
  cnt_t rank_q;
  smp_t ring_rd_q;
  smp_t value_q, value_d;
  logic rank_error_q, rank_error_d;

  // Arrival-order ring.
  logic [DataW-1:0] ring_mem [WindowMax];

  logic       in_acc;
  logic       sel_go;
  logic       full;
  cnt_t       cfg_eff;
  cnt_t       oldest_inc;
  idx_t       wr_addr;
  cnt_t       fill_inc;
  cnt_t       n_live;
  cnt_t       rank_m1;
  logic       bad_rank;
  chain_ctl_t ctl;
  smp_t       vals [WindowMax];

  // A finished result can move into the output register when it is empty or
  // being drained in this cycle.
  assign sel_go     = !out_valid_q || out_ready_i;
  assign in_ready_o = !upd_q && (!sel_q || sel_go);
  assign in_acc     = in_valid_i && in_ready_o;

  assign full       = (fill_q >= win_q);
  assign oldest_inc = {1'b0, oldest_q} + CntW'(1);
  assign fill_inc   = fill_q + CntW'(1);
  assign wr_addr    = full ? oldest_q : fill_q[IdxW-1:0];
  // Entries that stay valid once the oldest sample has left.
  assign n_live     = full ? (win_q - CntW'(1)) : fill_q;

  assign rank_m1    = rank_q - CntW'(1);
  assign bad_rank   = (rank_q == '0) || (rank_q > win_q);

  always_comb begin
    if (cfg_wdata_i == '0) begin
      cfg_eff = CntW'(1);
    end else if (cfg_wdata_i > CntW'(WindowMax)) begin
      cfg_eff = CntW'(WindowMax);
    end else begin
      cfg_eff = cfg_wdata_i;
    end
  end

  always_comb begin
    ctl.upd    = upd_q;
    ctl.rem    = full;
    ctl.vold   = ring_rd_q;
    ctl.sample = sample_q;
  end

  swrs_chain u_chain (
    .clk_i    (clk_i),
    .ctl_i    (ctl),
    .n_live_i (n_live),
    .vals_o   (vals)
  );

  always_comb begin
    win_d        = win_q;
    fill_d       = fill_q;
    oldest_d     = oldest_q;
    upd_d        = in_acc;
    sel_d        = sel_q;
    out_valid_d  = out_valid_q;
    value_d      = value_q;
    rank_error_d = rank_error_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    // The result is taken from the cells after the update edge.
    if (sel_q && sel_go) begin
      sel_d        = 1'b0;
      out_valid_d  = 1'b1;
      rank_error_d = bad_rank;
      value_d      = bad_rank ? '0 : vals[rank_m1[IdxW-1:0]];
    end

    if (upd_q) begin
      if (full) begin
        fill_d   = win_q;
        oldest_d = (oldest_inc >= win_q) ? '0 : oldest_inc[IdxW-1:0];
        sel_d    = 1'b1;
      end else begin
        fill_d   = fill_inc;
        oldest_d = '0;
        sel_d    = (fill_inc >= win_q);
      end
    end

    if (cfg_we_i) begin
      win_d    = cfg_eff;
      fill_d   = '0;
      oldest_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q       <= CntW'(1);
      fill_q      <= '0;
      oldest_q    <= '0;
      upd_q       <= 1'b0;
      sel_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      win_q       <= win_d;
      fill_q      <= fill_d;
      oldest_q    <= oldest_d;
      upd_q       <= upd_d;
      sel_q       <= sel_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q      <= value_d;
    rank_error_q <= rank_error_d;
    if (in_acc) begin
      sample_q <= sample_i;
      rank_q   <= rank_i;
    end
  end

  // Ring memory: read of the oldest slot at accept, write at update.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      ring_rd_q <= ring_mem[oldest_q];
    end
    if (upd_q) begin
      ring_mem[wr_addr] <= sample_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign value_o      = value_q;
  assign rank_error_o = rank_error_q;

  // The window never holds more samples than its configured size.
  a_fill_le_win: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= win_q)
    else $error("fill count exceeds window size");

  // The oldest pointer always names a slot inside the window.
  a_oldest_in_win: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, oldest_q} < win_q)
    else $error("oldest slot outside window");

  // A pending result is always loaded before the cells change again.
  a_upd_no_sel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd_q |-> !sel_q)
    else $error("cell update while a result is pending");

  // An accepted item always leads to a cell update, during which input is not ready.
  a_acc_upd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (upd_q && !in_ready_o))
    else $error("accepted item did not reach the update cycle");

endmodule

`default_nettype wire

### rtl/swrs_cell.sv
// One cell of the sorted chain: holds one entry and shifts with its neighbors.
`timescale 1ns / 1ps
`default_nettype none

module swrs_cell (
  input  wire                  clk_i,
  input  swrs_pkg::chain_ctl_t ctl_i,
  input  wire                  live_i,
  input  swrs_pkg::smp_t       right_i,
  input  swrs_pkg::smp_t       left_r_i,
  input  wire                  left_le_i,
  output swrs_pkg::smp_t       val_o,
  output swrs_pkg::smp_t       r_o,
  output logic                 le_o
);
  import swrs_pkg::*;

  smp_t val_q;
  smp_t val_d;
  smp_t r;
  smp_t ins;

  // Removal closes the gap from above; insertion then opens a gap at the first
  // entry greater than the new sample.
  always_comb begin
    r     = (ctl_i.rem && !(val_q < ctl_i.vold)) ? right_i : val_q;
    le_o  = (r <= ctl_i.sample);
    if (live_i && le_o) begin
      ins = r;
    end else if (left_le_i) begin
      ins = ctl_i.sample;
    end else begin
      ins = left_r_i;
    end
    val_d = ctl_i.upd ? ins : val_q;
  end

  assign r_o   = r;
  assign val_o = val_q;

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule

`default_nettype wire

### rtl/swrs_chain.sv
// Row of sorted cells; cell 0 holds the smallest sample of the window.
`timescale 1ns / 1ps
`default_nettype none

module swrs_chain (
  input  wire                  clk_i,
  input  swrs_pkg::chain_ctl_t ctl_i,
  input  swrs_pkg::cnt_t       n_live_i,
  output swrs_pkg::smp_t       vals_o [swrs_pkg::WindowMax]
);
  import swrs_pkg::*;

  smp_t r   [WindowMax];
  logic le  [WindowMax];

  for (genvar i = 0; i < WindowMax; i++) begin : g_cell
    smp_t right;
    smp_t left_r;
    logic left_le;
    logic live;

    if (i == WindowMax - 1) begin : g_last
      assign right = vals_o[i];
    end else begin : g_mid
      assign right = vals_o[i+1];
    end

    if (i == 0) begin : g_first
      assign left_r  = '0;
      assign left_le = 1'b1;
    end else begin : g_rest
      assign left_r  = r[i-1];
      assign left_le = le[i-1];
    end

    assign live = (CntW'(i) < n_live_i);

    swrs_cell u_cell (
      .clk_i     (clk_i),
      .ctl_i     (ctl_i),
      .live_i    (live),
      .right_i   (right),
      .left_r_i  (left_r),
      .left_le_i (left_le),
      .val_o     (vals_o[i]),
      .r_o       (r[i]),
      .le_o      (le[i])
    );
  end

endmodule

`default_nettype wire
